### rtl/rufp_pkg.sv
// Shared types, constants and the header matcher function of the frame parser.
package rufp_pkg;

  // Header bytes in arrival order.
  localparam logic [7:0] HdrByte0 = 8'hFA;
  localparam logic [7:0] HdrByte1 = 8'hF5;
  localparam logic [7:0] HdrByte2 = 8'hAA;
  localparam logic [7:0] HdrByte3 = 8'hA5;

  // Sum of the four header bytes, the seed of the running checksum.
  localparam logic [15:0] HdrSum = 16'h033E;

  // Accepted frame length range in bytes.
  localparam logic [7:0] MinFrame = 8'd10;
  localparam logic [7:0] MaxFrame = 8'd128;

  // Offsets within a frame.
  localparam logic [7:0] IdxLenLow  = 8'd4;
  localparam logic [7:0] IdxLenHigh = 8'd5;
  localparam logic [7:0] IdxBody    = 8'd6;
  localparam logic [7:0] IdxType    = 8'd7;

  // Header bytes matched by the hunter, a complete header included.
  localparam logic [2:0] MatchNone = 3'd0;
  localparam logic [2:0] MatchOne  = 3'd1;
  localparam logic [2:0] MatchFull = 3'd4;

  // One result beat.
  typedef struct packed {
    logic [7:0] frame_type;
    logic [7:0] total_len;
    logic       checksum_ok;
  } rufp_result_t;

  // Advance the header matcher by one byte; a mismatching FA restarts at one.
  function automatic logic [2:0] hunt_next(input logic [1:0] match, input logic [7:0] rx);
    logic [7:0] expected;
    begin
      case (match)
        2'd0:    expected = HdrByte0;
        2'd1:    expected = HdrByte1;
        2'd2:    expected = HdrByte2;
        default: expected = HdrByte3;
      endcase
      if (rx == expected) begin
        hunt_next = {1'b0, match} + 3'd1;
      end else if (rx == HdrByte0) begin
        hunt_next = MatchOne;
      end else begin
        hunt_next = MatchNone;
      end
    end
  endfunction

endpackage

### rtl/rufp_ifs.sv
// Valid/ready channel interfaces for received bytes and parsed frame results.
interface rufp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface rufp_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_type;
  logic [7:0] total_len;
  logic       checksum_ok;

  modport source (output valid, output frame_type, output total_len,
                  output checksum_ok, input ready);
  modport sink (input valid, input frame_type, input total_len,
                input checksum_ok, output ready);
endinterface

### rtl/radar_uart_frame_parser_unit.sv
// Top level of the byte-serial header/length/checksum frame parser.
//
//   Port      Dir   Beat contents
//   byte_i    in    rx_byte: one received serial byte
//   result_o  out   frame_type, total_len, checksum_ok of one completed frame
//
// One byte is taken every cycle unless the result stalls; the result of a frame
// is formed from the input register, then held in the result register.
// Reset clears the input and result valid flags and the parser state.
// A stalled result holds the parser; the input register then holds one byte
// and byte_i.ready drops until the result is taken.
module radar_uart_frame_parser_unit import rufp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  rufp_byte_if.sink     byte_i,
  rufp_result_if.source result_o
);

  logic         advance;
  logic         in_valid;
  logic [7:0]   in_byte;
  logic         step;
  logic         res_valid;
  rufp_result_t res_comb;
  rufp_result_t res_reg;
  logic         out_valid;

  // Input register.
  rufp_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (byte_i.valid),
    .byte_i    (byte_i.rx_byte),
    .advance_i (advance),
    .ready_o   (byte_i.ready),
    .valid_o   (in_valid),
    .byte_o    (in_byte)
  );

  assign step = in_valid && advance;

  // Parser state and next-state logic.
  rufp_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte),
    .res_valid_o (res_valid),
    .res_o       (res_comb)
  );

  // Result register.
  rufp_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (res_valid),
    .res_i     (res_comb),
    .ready_i   (result_o.ready),
    .advance_o (advance),
    .valid_o   (out_valid),
    .res_o     (res_reg)
  );

  assign result_o.valid       = out_valid;
  assign result_o.frame_type  = res_reg.frame_type;
  assign result_o.total_len   = res_reg.total_len;
  assign result_o.checksum_ok = res_reg.checksum_ok;

  // The input side only stalls while a byte is held behind a waiting result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !byte_i.ready |-> (in_valid && out_valid && !result_o.ready))
    else $error("input stalled without a blocked result");

  // A reported frame length always lies in the accepted range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (res_reg.total_len >= MinFrame && res_reg.total_len <= MaxFrame))
    else $error("result frame length out of range");

  // A parser step with a result always leaves a valid result in the register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && res_valid) |=> out_valid)
    else $error("parsed result was lost");

endmodule

### rtl/rufp_in_reg.sv
// Input register stage holding one received byte until the parser takes it.
module rufp_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] byte_i,
  input  logic       advance_i,
  output logic       ready_o,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       accept;

  // The stage frees itself whenever the parser moves on.
  assign ready_o = !valid_q || advance_i;
  assign accept  = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

### rtl/rufp_fsm.sv
// Frame parser state: header hunt, length check, checksum and result forming.
module rufp_fsm import rufp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic [7:0]   byte_i,
  output logic         res_valid_o,
  output rufp_result_t res_o
);

  logic [1:0]  match_q, match_d;
  logic        in_frame_q, in_frame_d;
  logic [7:0]  index_q, index_d;
  logic [7:0]  len_low_q, len_low_d;
  logic [7:0]  exp_len_q, exp_len_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  trail_low_q, trail_low_d;

  logic [2:0]  hunt_m;
  logic [2:0]  rescan_first;
  logic [2:0]  rescan_m;
  logic        bad_len;
  logic [8:0]  tail_pos;
  logic [15:0] sum_add;

  assign hunt_m       = hunt_next(match_q, byte_i);
  assign rescan_first = hunt_next(2'd0, len_low_q);
  assign rescan_m     = hunt_next(rescan_first[1:0], byte_i);
  assign bad_len  = (byte_i != 8'd0) || (len_low_q < MinFrame) || (len_low_q > MaxFrame);
  assign tail_pos = {1'b0, index_q} + 9'd2;
  assign sum_add  = sum_q + {8'd0, byte_i};

  // Next state for one byte.
  always_comb begin
    match_d     = match_q;
    in_frame_d  = in_frame_q;
    index_d     = index_q;
    len_low_d   = len_low_q;
    exp_len_d   = exp_len_q;
    type_d      = type_q;
    sum_d       = sum_q;
    trail_low_d = trail_low_q;
    res_valid_o = 1'b0;
    res_o.frame_type  = type_q;
    res_o.total_len   = exp_len_q;
    res_o.checksum_ok = ({byte_i, trail_low_q} == sum_q);
    if (step_i) begin
      if (!in_frame_q) begin
        if (hunt_m == MatchFull) begin
          match_d    = 2'd0;
          in_frame_d = 1'b1;
          index_d    = IdxLenLow;
          sum_d      = HdrSum;
        end else begin
          match_d = hunt_m[1:0];
        end
      end else if (index_q == IdxLenLow) begin
        len_low_d = byte_i;
        sum_d     = sum_add;
        index_d   = IdxLenHigh;
      end else if (index_q == IdxLenHigh) begin
        if (bad_len) begin
          // Drop the header and rescan both length bytes from idle.
          in_frame_d = 1'b0;
          index_d    = 8'd0;
          match_d    = rescan_m[1:0];
        end else begin
          exp_len_d = len_low_q;
          sum_d     = sum_add;
          index_d   = IdxBody;
        end
      end else begin
        if (index_q == IdxType) begin
          type_d = byte_i;
        end
        if (tail_pos < {1'b0, exp_len_q}) begin
          sum_d   = sum_add;
          index_d = index_q + 8'd1;
        end else if (tail_pos == {1'b0, exp_len_q}) begin
          trail_low_d = byte_i;
          index_d     = index_q + 8'd1;
        end else begin
          res_valid_o = 1'b1;
          in_frame_d  = 1'b0;
          index_d     = 8'd0;
          match_d     = 2'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q     <= 2'd0;
      in_frame_q  <= 1'b0;
      index_q     <= 8'd0;
      len_low_q   <= 8'd0;
      exp_len_q   <= 8'd0;
      type_q      <= 8'd0;
      sum_q       <= 16'd0;
      trail_low_q <= 8'd0;
    end else begin
      match_q     <= match_d;
      in_frame_q  <= in_frame_d;
      index_q     <= index_d;
      len_low_q   <= len_low_d;
      exp_len_q   <= exp_len_d;
      type_q      <= type_d;
      sum_q       <= sum_d;
      trail_low_q <= trail_low_d;
    end
  end

endmodule

### rtl/rufp_out_reg.sv
// Result register that holds a parsed frame beat until the sink takes it.
module rufp_out_reg import rufp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  rufp_result_t res_i,
  input  logic         ready_i,
  output logic         advance_o,
  output logic         valid_o,
  output rufp_result_t res_o
);

  logic         valid_q, valid_d;
  rufp_result_t res_q;

  // The parser may step when the register is empty or being drained.
  assign advance_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (advance_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
